// ===== src/assert_macros.svh =====
// Assertion macros used by the RTL top level, fixed_point_alu.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is low.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Clocked property, checked during reset too.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ===== src/fpa_pkg.sv =====
// Package: opcodes, control struct and saturation helper for the fixed-point ALU.
`default_nettype none
package fpa_pkg;
    localparam int FRAC_BITS_DEF = 8;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_INC = 3'd4;
    localparam logic [2:0] OP_DEC = 3'd5;
    localparam logic [2:0] OP_MIN = 3'd6;
    localparam logic [2:0] OP_MAX = 3'd7;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] res;
        logic        ovf;
        logic        lt;
        logic        eq;
        logic        gt;
        logic        neg;
        logic        dz;
        logic [63:0] prod;
    } t_ctl;

    typedef struct packed {
        logic [31:0] val;
        logic        ovf;
    } t_sat;

    function automatic t_sat sat33(input logic signed [32:0] v);
        t_sat s;
        if (v > 33'sh0_7FFF_FFFF) begin
            s.val = 32'h7FFF_FFFF;
            s.ovf = 1'b1;
        end else if (v < -33'sh0_8000_0000) begin
            s.val = 32'h8000_0000;
            s.ovf = 1'b1;
        end else begin
            s.val = v[31:0];
            s.ovf = 1'b0;
        end
        return s;
    endfunction
endpackage
`default_nettype wire

// ===== src/fpa_in_if.sv =====
// Input channel: opcode and two operands with valid/ready.
`default_nettype none
interface fpa_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         opcode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    modport source (output valid, opcode, operand_a, operand_b, input ready);
    modport sink (input valid, opcode, operand_a, operand_b, output ready);
endinterface
`default_nettype wire

// ===== src/fpa_out_if.sv =====
// Output channel: result and flags with valid/ready.
`default_nettype none
interface fpa_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] result_value;
    logic               a_less;
    logic               a_equal;
    logic               a_greater;
    logic               divide_by_zero;
    logic               overflow;
    modport source (output valid, result_value, a_less, a_equal, a_greater,
                    divide_by_zero, overflow, input ready);
    modport sink (input valid, result_value, a_less, a_equal, a_greater,
                  divide_by_zero, overflow, output ready);
endinterface
`default_nettype wire

// ===== src/fixed_point_alu.sv =====
// Top level: signed fixed-point ALU with pipelined multiply and divide.
// Every opcode travels one shared pipeline of 34 + FRAC_BITS register stages
// (front decode, one stage per quotient bit of the restoring divider, output
// register); one beat is accepted each cycle while the pipeline is enabled.
// The pipeline advances as one unit whenever the output register is empty or
// being drained; i_in.ready follows that enable.
`default_nettype none
`include "assert_macros.svh"
module fixed_point_alu #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    fpa_in_if.sink       i_in,
    fpa_out_if.source    o_out
);
    import fpa_pkg::*;

    localparam int NW = 32 + FRAC_BITS;

    logic           en;
    logic           s_valid [0:NW];
    t_ctl           s_ctl   [0:NW];
    logic [NW+31:0] s_rq    [0:NW];
    logic [31:0]    s_d     [0:NW];
    logic           f_valid;
    t_ctl           f_ctl;
    logic [31:0]    f_ma;
    logic [31:0]    f_mb;

    logic           r_out_valid;
    logic [31:0]    r_res;
    logic           r_lt;
    logic           r_eq;
    logic           r_gt;
    logic           r_dz;
    logic           r_ovf;
    logic [31:0]    n_res;
    logic           n_ovf;
    logic [63:0]    mag;
    t_ctl           last;

    assign en = !r_out_valid || o_out.ready;
    assign i_in.ready = en;

    fpa_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_in.valid),
        .i_opcode (i_in.opcode),
        .i_a      (i_in.operand_a),
        .i_b      (i_in.operand_b),
        .o_valid  (f_valid),
        .o_ctl    (f_ctl),
        .o_ma     (f_ma),
        .o_mb     (f_mb)
    );

    always_comb begin
        s_valid[0]     = f_valid;
        s_ctl[0]       = f_ctl;
        s_ctl[0].prod  = 64'(f_ma) * 64'(f_mb);
        s_rq[0]        = {32'd0, f_ma, FRAC_BITS'(0)};
        s_d[0]         = f_mb;
    end

    for (genvar k = 0; k < NW; k++) begin : g_div
        fpa_div_stage #(.NW(NW)) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (s_valid[k]),
            .i_ctl   (s_ctl[k]),
            .i_rq    (s_rq[k]),
            .i_d     (s_d[k]),
            .o_valid (s_valid[k+1]),
            .o_ctl   (s_ctl[k+1]),
            .o_rq    (s_rq[k+1]),
            .o_d     (s_d[k+1])
        );
    end

    always_comb begin
        last = s_ctl[NW];
        mag  = (last.op == OP_MUL) ? (last.prod >> FRAC_BITS) : 64'(s_rq[NW][NW-1:0]);
        n_res = last.res;
        n_ovf = last.ovf;
        if (last.dz) begin
            n_res = 32'd0;
            n_ovf = 1'b0;
        end else if (last.op == OP_MUL || last.op == OP_DIV) begin
            if (last.neg) begin
                n_ovf = mag > 64'h8000_0000;
                n_res = n_ovf ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
            end else begin
                n_ovf = mag > 64'h7FFF_FFFF;
                n_res = n_ovf ? 32'h7FFF_FFFF : mag[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= s_valid[NW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res <= n_res;
            r_lt  <= last.lt;
            r_eq  <= last.eq;
            r_gt  <= last.gt;
            r_dz  <= last.dz;
            r_ovf <= n_ovf;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.result_value   = r_res;
    assign o_out.a_less         = r_lt;
    assign o_out.a_equal        = r_eq;
    assign o_out.a_greater      = r_gt;
    assign o_out.divide_by_zero = r_dz;
    assign o_out.overflow       = r_ovf;

    `ASSERT_CLK(a_cmp_onehot, i_clk, i_rst_n, o_out.valid |-> $onehot({r_lt, r_eq, r_gt}))
    `ASSERT_CLK(a_dz_zero, i_clk, i_rst_n, (o_out.valid && r_dz) |-> (r_res == 32'd0 && !r_ovf))
    `ASSERT_ALWAYS(a_ready_empty, i_clk, !o_out.valid |-> i_in.ready)
endmodule
`default_nettype wire

// ===== src/fpa_front.sv =====
// Front stage: decode, compare, add/sub/inc/dec/min/max, operand magnitudes.
`default_nettype none
module fpa_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_valid,
    input  wire  [2:0]          i_opcode,
    input  wire  signed [31:0]  i_a,
    input  wire  signed [31:0]  i_b,
    output logic                o_valid,
    output fpa_pkg::t_ctl       o_ctl,
    output logic [31:0]         o_ma,
    output logic [31:0]         o_mb
);
    import fpa_pkg::*;

    logic        r_valid;
    t_ctl        r_ctl;
    t_ctl        n_ctl;
    logic [31:0] r_ma;
    logic [31:0] r_mb;
    logic [31:0] n_ma;
    logic [31:0] n_mb;
    t_sat        sat;

    always_comb begin
        n_ma = i_a[31] ? (~i_a + 32'd1) : i_a;
        n_mb = i_b[31] ? (~i_b + 32'd1) : i_b;
        unique case (i_opcode)
            OP_ADD:  sat = sat33(33'(i_a) + 33'(i_b));
            OP_SUB:  sat = sat33(33'(i_a) - 33'(i_b));
            OP_INC:  sat = sat33(33'(i_a) + 33'sd1);
            OP_DEC:  sat = sat33(33'(i_a) - 33'sd1);
            OP_MIN:  sat = '{val: (i_a < i_b) ? i_a : i_b, ovf: 1'b0};
            OP_MAX:  sat = '{val: (i_a > i_b) ? i_a : i_b, ovf: 1'b0};
            default: sat = '{val: 32'd0, ovf: 1'b0};
        endcase
        n_ctl.op   = i_opcode;
        n_ctl.res  = sat.val;
        n_ctl.ovf  = sat.ovf;
        n_ctl.lt   = i_a < i_b;
        n_ctl.eq   = i_a == i_b;
        n_ctl.gt   = i_a > i_b;
        n_ctl.neg  = i_a[31] != i_b[31];
        n_ctl.dz   = (i_opcode == OP_DIV) && (i_b == 32'sd0);
        n_ctl.prod = 64'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl <= n_ctl;
            r_ma  <= n_ma;
            r_mb  <= n_mb;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_ma    = r_ma;
    assign o_mb    = r_mb;
endmodule
`default_nettype wire

// ===== src/fpa_div_stage.sv =====
// One restoring division step: one quotient bit per stage, control carried along.
`default_nettype none
module fpa_div_stage #(
    parameter int NW = 40
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_en,
    input  wire                 i_valid,
    input  fpa_pkg::t_ctl       i_ctl,
    input  wire  [NW+31:0]      i_rq,
    input  wire  [31:0]         i_d,
    output logic                o_valid,
    output fpa_pkg::t_ctl       o_ctl,
    output logic [NW+31:0]      o_rq,
    output logic [31:0]         o_d
);
    import fpa_pkg::*;

    logic           r_valid;
    t_ctl           r_ctl;
    logic [NW+31:0] r_rq;
    logic [NW+31:0] n_rq;
    logic [31:0]    r_d;
    logic [32:0]    shifted;
    logic [32:0]    diff;

    always_comb begin
        shifted = {i_rq[NW+31:NW], i_rq[NW-1]};
        diff    = shifted - {1'b0, i_d};
        if (!diff[32]) begin
            n_rq = {diff[31:0], i_rq[NW-2:0], 1'b1};
        end else begin
            n_rq = {shifted[31:0], i_rq[NW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ctl <= i_ctl;
            r_rq  <= n_rq;
            r_d   <= i_d;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_rq    = r_rq;
    assign o_d     = r_d;
endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for fixed_point_alu: a golden model predicts each beat, a scoreboard checks it.
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import fpa_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam int N_RANDOM = 1450;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 34 + FB + 20;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] a;
        logic [31:0] b;
    } alu_op_t;

    typedef struct packed {
        logic [31:0] value;
        logic        lt;
        logic        eq;
        logic        gt;
        logic        dz;
        logic        ovf;
    } alu_res_t;

    logic i_clk;
    logic i_rst_n;

    fpa_in_if  in_ch ();
    fpa_out_if out_ch ();

    fixed_point_alu #(.FRAC_BITS(FB)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    alu_op_t  pending_ops[$];
    alu_res_t expected_results[$];
    int       mismatches;
    int       idle_cycles;
    int       send_gap;
    int       recv_gap;
    bit       timed_out;
    bit       in_taken;
    bit       out_taken;

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic logic [31:0] saturate(input logic signed [65:0] v, output logic ovf);
        ovf = 1'b0;
        if (v > 66'sd2147483647) begin
            ovf = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -66'sd2147483648) begin
            ovf = 1'b1;
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    function automatic alu_res_t predict_alu(input alu_op_t x);
        alu_res_t r;
        logic signed [65:0] sa, sb, t;
        logic [65:0] ma, mb, m;
        logic neg;
        sa = 66'(signed'(x.a));
        sb = 66'(signed'(x.b));
        ma = sa < 0 ? 66'(-sa) : 66'(sa);
        mb = sb < 0 ? 66'(-sb) : 66'(sb);
        neg = (sa < 0) != (sb < 0);
        r = '0;
        case (x.op)
            OP_ADD: r.value = saturate(sa + sb, r.ovf);
            OP_SUB: r.value = saturate(sa - sb, r.ovf);
            OP_MUL: begin
                m = (ma * mb) >> FB;
                t = neg ? -$signed(m) : $signed(m);
                r.value = saturate(t, r.ovf);
            end
            OP_DIV: begin
                if (sb == 0) begin
                    r.dz = 1'b1;
                end else begin
                    m = (ma << FB) / mb;
                    t = neg ? -$signed(m) : $signed(m);
                    r.value = saturate(t, r.ovf);
                end
            end
            OP_INC: r.value = saturate(sa + 1, r.ovf);
            OP_DEC: r.value = saturate(sa - 1, r.ovf);
            OP_MIN: r.value = sa < sb ? x.a : x.b;
            default: r.value = sa > sb ? x.a : x.b;
        endcase
        r.lt = sa < sb;
        r.eq = sa == sb;
        r.gt = sa > sb;
        return r;
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 5))
            0: return 32'($signed($urandom_range(0, 2048)) - 1024);
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                           : 32'h8000_0000 + $urandom_range(0, 3);
            2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            3: return $urandom_range(0, 3) == 0 ? 32'd0 : 32'($urandom_range(0, 1 << 16));
            default: return $urandom;
        endcase
    endfunction

    task automatic add_op(input logic [2:0] op, input logic [31:0] a, input logic [31:0] b);
        alu_op_t x;
        x.op = op;
        x.a = a;
        x.b = b;
        pending_ops.push_back(x);
    endtask

    always @(posedge i_clk) begin
        in_taken  <= in_ch.valid && in_ch.ready;
        out_taken <= out_ch.valid && out_ch.ready;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_taken) begin
            void'(pending_ops.pop_front());
            send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
            if (send_gap == 0 && pending_ops.size() > 0) begin
                in_ch.opcode    <= pending_ops[0].op;
                in_ch.operand_a <= pending_ops[0].a;
                in_ch.operand_b <= pending_ops[0].b;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end else if (!in_ch.valid && pending_ops.size() > 0) begin
            if (send_gap > 0) begin
                send_gap--;
            end else begin
                in_ch.valid     <= 1'b1;
                in_ch.opcode    <= pending_ops[0].op;
                in_ch.operand_a <= pending_ops[0].a;
                in_ch.operand_b <= pending_ops[0].b;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (out_taken) begin
            recv_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
            out_ch.ready <= recv_gap == 0;
        end else if (!out_ch.ready) begin
            if (recv_gap > 0) begin
                recv_gap--;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        alu_res_t got, want;
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                expected_results.push_back(predict_alu({in_ch.opcode, in_ch.operand_a,
                                                        in_ch.operand_b}));
            end
            if (out_ch.valid && out_ch.ready) begin
                got = {out_ch.result_value, out_ch.a_less, out_ch.a_equal,
                       out_ch.a_greater, out_ch.divide_by_zero, out_ch.overflow};
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat: %h", got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected val=%h lt%b eq%b gt%b dz%b ovf%b,",
                                      " got val=%h lt%b eq%b gt%b dz%b ovf%b"},
                                     want.value, want.lt, want.eq, want.gt, want.dz, want.ovf,
                                     got.value, got.lt, got.eq, got.gt, got.dz, got.ovf);
                    end
                end
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                    || (pending_ops.size() == 0 && expected_results.size() == 0))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("tb: FAIL");
            $finish;
        end
    end

    initial begin
        logic [31:0] extremes[6];
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_ADD;
        in_ch.operand_a = '0;
        in_ch.operand_b = '0;
        out_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        mismatches = 0;
        idle_cycles = 0;
        send_gap = 0;
        recv_gap = 0;
        timed_out = 1'b0;
        extremes = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'hFFFF_FFFF, 32'd256,
                     32'hFFFF_FF00};
        add_op(OP_ADD, 32'h7FFF_FFFF, 32'd1);
        add_op(OP_ADD, 32'h8000_0000, 32'hFFFF_FFFF);
        add_op(OP_SUB, 32'h8000_0000, 32'd1);
        add_op(OP_SUB, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        add_op(OP_MUL, 32'h8000_0000, 32'h8000_0000);
        add_op(OP_MUL, 32'h8000_0000, 32'h7FFF_FFFF);
        add_op(OP_MUL, 32'hFFFF_FFFF, 32'd1);
        add_op(OP_DIV, 32'd5, 32'd0);
        add_op(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
        add_op(OP_DIV, 32'hFFFF_FD00, 32'd512);
        add_op(OP_DIV, 32'h7FFF_FFFF, 32'd1);
        add_op(OP_INC, 32'h7FFF_FFFF, 32'h8000_0000);
        add_op(OP_DEC, 32'h8000_0000, 32'h7FFF_FFFF);
        add_op(OP_INC, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_op(OP_MIN, 32'h8000_0000, 32'h7FFF_FFFF);
        add_op(OP_MAX, 32'h8000_0000, 32'h7FFF_FFFF);
        add_op(OP_MIN, 32'd7, 32'd7);
        add_op(OP_MAX, 32'hFFFF_FFF0, 32'hFFFF_FFF0);
        for (int k = 0; k < 6; k++)
            add_op(3'(k + 2), extremes[k], extremes[5 - k]);
        for (int k = 0; k < N_RANDOM; k++)
            add_op(3'($urandom_range(0, 7)), rand_operand(),
                   $urandom_range(0, 7) == 0 ? 32'd0 : rand_operand());
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (pending_ops.size() == 0);
        wait (expected_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+src
src/fpa_pkg.sv
src/fpa_in_if.sv
src/fpa_out_if.sv
src/fpa_front.sv
src/fpa_div_stage.sv
src/fixed_point_alu.sv
tb/tb.sv
